/* rtl/adsb_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and field decode functions of the extended squitter decoder.
package adsb_pkg;

  localparam int ADSB_FRAME_LEN   = 14;
  localparam int ADSB_QUEUE_DEPTH = 2;
  localparam int ADSB_ME_BITS     = 56;

  // Frame kind chosen by the front end; each has its own field list
  typedef enum logic [3:0] {
    K_IDENT,
    K_SURFACE,
    K_AIRBORNE,
    K_VELOCITY,
    K_TEST_DATA,
    K_TEST_ACODE,
    K_EMERGENCY,
    K_TARGET_STATE,
    K_OP_STATUS
  } kind_t;

  // Message class codes on the output
  localparam logic [2:0] CLS_IDENT        = 3'd0;
  localparam logic [2:0] CLS_SURFACE      = 3'd1;
  localparam logic [2:0] CLS_AIRBORNE     = 3'd2;
  localparam logic [2:0] CLS_VELOCITY     = 3'd3;
  localparam logic [2:0] CLS_TEST         = 3'd4;
  localparam logic [2:0] CLS_EMERGENCY    = 3'd5;
  localparam logic [2:0] CLS_TARGET_STATE = 3'd6;
  localparam logic [2:0] CLS_OP_STATUS    = 3'd7;

  // One accepted frame handed from front to back
  typedef struct packed {
    kind_t                    kind;
    logic [23:0]              addr;
    logic [ADSB_ME_BITS-1:0]  me;
  } adsb_desc_t;

  function automatic logic [2:0] kind_class(input kind_t k);
    logic [2:0] c;
    case (k)
      K_IDENT:        c = CLS_IDENT;
      K_SURFACE:      c = CLS_SURFACE;
      K_AIRBORNE:     c = CLS_AIRBORNE;
      K_VELOCITY:     c = CLS_VELOCITY;
      K_TEST_DATA:    c = CLS_TEST;
      K_TEST_ACODE:   c = CLS_TEST;
      K_EMERGENCY:    c = CLS_EMERGENCY;
      K_TARGET_STATE: c = CLS_TARGET_STATE;
      K_OP_STATUS:    c = CLS_OP_STATUS;
      default:        c = CLS_IDENT;
    endcase
    return c;
  endfunction

  function automatic logic [4:0] kind_count(input kind_t k);
    logic [4:0] n;
    case (k)
      K_IDENT:        n = 5'd10;
      K_SURFACE:      n = 5'd8;
      K_AIRBORNE:     n = 5'd8;
      K_VELOCITY:     n = 5'd15;
      K_TEST_DATA:    n = 5'd8;
      K_TEST_ACODE:   n = 5'd3;
      K_EMERGENCY:    n = 5'd3;
      K_TARGET_STATE: n = 5'd18;
      K_OP_STATUS:    n = 5'd12;
      default:        n = 5'd1;
    endcase
    return n;
  endfunction

  // Six-bit identification character to ASCII
  function automatic logic [7:0] id_char(input logic [5:0] c);
    logic [7:0] r;
    case (c[5:4])
      2'd0:    r = 8'h40 + {4'd0, c[3:0]};
      2'd1:    r = 8'h50 + {4'd0, c[3:0]};
      2'd2:    r = (c[3:0] == 4'd0) ? 8'h20 : 8'h00;
      default: r = 8'h30 + {4'd0, c[3:0]};
    endcase
    return r;
  endfunction

  // Field value for one position of a kind's list, sliced from the ME bytes
  function automatic logic [16:0] field_val(input kind_t k, input logic [4:0] idx,
                                            input logic [ADSB_ME_BITS-1:0] me);
    logic [7:0]  b0, b1, b2, b3, b4, b5, b6;
    logic [16:0] v;
    b0 = me[55:48]; b1 = me[47:40]; b2 = me[39:32]; b3 = me[31:24];
    b4 = me[23:16]; b5 = me[15:8];  b6 = me[7:0];
    v = 17'd0;
    case (k)
      K_IDENT: begin
        case (idx)
          5'd0:    v = 17'(b0[7:3]);
          5'd1:    v = 17'(b0[2:0]);
          5'd2:    v = 17'(id_char(b1[7:2]));
          5'd3:    v = 17'(id_char({b1[1:0], b2[7:4]}));
          5'd4:    v = 17'(id_char({b2[3:0], b3[7:6]}));
          5'd5:    v = 17'(id_char(b3[5:0]));
          5'd6:    v = 17'(id_char(b4[7:2]));
          5'd7:    v = 17'(id_char({b4[1:0], b5[7:4]}));
          5'd8:    v = 17'(id_char({b5[3:0], b6[7:6]}));
          default: v = 17'(id_char(b6[5:0]));
        endcase
      end
      K_SURFACE, K_AIRBORNE: begin
        case (idx)
          5'd0:    v = 17'(b0[7:3]);
          5'd1:    v = (k == K_SURFACE) ? 17'({b0[2:0], b1[7:4]}) : 17'(b0[2:1]);
          5'd2:    v = (k == K_SURFACE) ? 17'(b1[3]) : 17'(b0[0]);
          5'd3:    v = (k == K_SURFACE) ? 17'({b1[2:0], b2[7:4]}) : 17'({b1, b2[7:4]});
          5'd4:    v = 17'(b2[3]);
          5'd5:    v = 17'(b2[2]);
          5'd6:    v = {b2[1:0], b3, b4[7:1]};
          default: v = {b4[0], b5, b6};
        endcase
      end
      K_VELOCITY: begin
        case (idx)
          5'd0:    v = 17'(b0[7:3]);
          5'd1:    v = 17'(b0[2:0]);
          5'd2:    v = 17'(b1[7]);
          5'd3:    v = 17'(b1[6]);
          5'd4:    v = 17'(b1[5:3]);
          5'd5:    v = 17'(b1[2]);
          5'd6:    v = 17'({b1[1:0], b2});
          5'd7:    v = 17'(b3[7]);
          5'd8:    v = 17'({b3[6:0], b4[7:5]});
          5'd9:    v = 17'(b4[4]);
          5'd10:   v = 17'(b4[3]);
          5'd11:   v = 17'({b4[2:0], b5[7:2]});
          5'd12:   v = 17'(b5[1:0]);
          5'd13:   v = 17'(b6[7]);
          default: v = 17'(b6[6:0]);
        endcase
      end
      K_TEST_DATA: begin
        case (idx)
          5'd0:    v = 17'(b0[7:3]);
          5'd1:    v = 17'(b0[2:0]);
          5'd2:    v = 17'(b1);
          5'd3:    v = 17'(b2);
          5'd4:    v = 17'(b3);
          5'd5:    v = 17'(b4);
          5'd6:    v = 17'(b5);
          default: v = 17'(b6);
        endcase
      end
      K_TEST_ACODE: begin
        case (idx)
          5'd0:    v = 17'(b0[7:3]);
          5'd1:    v = 17'(b0[2:0]);
          default: v = 17'({b1, b2[7:3]});
        endcase
      end
      K_EMERGENCY: begin
        case (idx)
          5'd0:    v = 17'(b0[7:3]);
          5'd1:    v = 17'(b0[2:0]);
          default: v = 17'(b1[7:5]);
        endcase
      end
      K_TARGET_STATE: begin
        case (idx)
          5'd0:    v = 17'(b0[7:3]);
          5'd1:    v = 17'(b0[2:1]);
          5'd2:    v = 17'({b0[0], b1[7]});
          5'd3:    v = 17'(b1[6]);
          5'd4:    v = 17'(b1[5]);
          5'd5:    v = 17'(b1[4:3]);
          5'd6:    v = 17'(b1[2:1]);
          5'd7:    v = 17'({b1[0], b2, b3[7]});
          5'd8:    v = 17'(b3[6:5]);
          5'd9:    v = 17'({b3[4:0], b4[7:4]});
          5'd10:   v = 17'(b4[3]);
          5'd11:   v = 17'(b4[2:1]);
          5'd12:   v = 17'({b4[0], b5[7:5]});
          5'd13:   v = 17'(b5[4]);
          5'd14:   v = 17'(b5[3:2]);
          5'd15:   v = 17'({b5[1:0], b6[7:5]});
          5'd16:   v = 17'(b6[4:3]);
          default: v = 17'(b6[2:0]);
        endcase
      end
      K_OP_STATUS: begin
        case (idx)
          5'd0:    v = 17'(b0[7:3]);
          5'd1:    v = 17'(b0[2:0]);
          5'd2:    v = 17'({b1, b2});
          5'd3:    v = 17'({b3, b4});
          5'd4:    v = 17'(b5[7:5]);
          5'd5:    v = 17'(b5[4]);
          5'd6:    v = 17'(b5[3:0]);
          5'd7:    v = 17'(b6[7:6]);
          5'd8:    v = 17'(b6[5:4]);
          5'd9:    v = 17'(b6[3]);
          5'd10:   v = 17'(b6[2]);
          default: v = 17'(b6[1:0]);
        endcase
      end
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/adsb_front.sv */
`timescale 1ns / 1ps
// Front end: collects frame bytes, checks length and format, classifies the ME.
module adsb_front import adsb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       q_full,
  output logic       push,
  output adsb_desc_t push_desc
);

  localparam int CntW = $clog2(ADSB_FRAME_LEN + 2);

  logic [7:0]      frame_bytes [ADSB_FRAME_LEN];
  logic [CntW-1:0] byte_count;
  logic            take;
  logic            fmt_ok;
  logic            handled;
  logic [4:0]      df, tc;
  logic [2:0]      cf, st;
  kind_t           kind;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  // Store bytes in frame order, drop those past the frame length
  always_ff @(posedge clk) begin
    if (take && (byte_count < CntW'(ADSB_FRAME_LEN))) begin
      frame_bytes[byte_count[$clog2(ADSB_FRAME_LEN)-1:0]] <= in_byte;
    end
  end

  // Count bytes, saturate on overlong frames, restart at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (take) begin
      if (in_last) begin
        byte_count <= '0;
      end else if (byte_count < CntW'(ADSB_FRAME_LEN + 1)) begin
        byte_count <= byte_count + CntW'(1);
      end
    end
  end

  // Check format: the closing byte must be the last one of a full frame
  always_comb begin
    df = frame_bytes[0][7:3];
    cf = frame_bytes[0][2:0];
    tc = frame_bytes[4][7:3];
    st = frame_bytes[4][2:0];
    fmt_ok = (byte_count == CntW'(ADSB_FRAME_LEN - 1)) &&
             ((df == 5'd17) ||
              ((df == 5'd18) && ((cf == 3'd0) || (cf == 3'd2) || (cf == 3'd3) ||
                                 (cf == 3'd5))) ||
              ((df == 5'd19) && (cf == 3'd0)));
  end

  // Classify on type code and subtype
  always_comb begin
    handled = 1'b1;
    kind    = K_IDENT;
    if ((tc >= 5'd1) && (tc <= 5'd4)) begin
      kind = K_IDENT;
    end else if ((tc >= 5'd5) && (tc <= 5'd8)) begin
      kind = K_SURFACE;
    end else if (((tc >= 5'd9) && (tc <= 5'd18)) || ((tc >= 5'd20) && (tc <= 5'd22))) begin
      kind = K_AIRBORNE;
    end else if ((tc == 5'd19) && (st >= 3'd1) && (st <= 3'd4)) begin
      kind = K_VELOCITY;
    end else if ((tc == 5'd23) && (st == 3'd0)) begin
      kind = K_TEST_DATA;
    end else if ((tc == 5'd23) && (st == 3'd7)) begin
      kind = K_TEST_ACODE;
    end else if ((tc == 5'd28) && (st == 3'd1)) begin
      kind = K_EMERGENCY;
    end else if ((tc == 5'd29) && (st[2:1] == 2'd0)) begin
      kind = K_TARGET_STATE;
    end else if ((tc == 5'd31) && ((st == 3'd0) || (st == 3'd1))) begin
      kind = K_OP_STATUS;
    end else begin
      handled = 1'b0;
    end
  end

  assign push           = take && in_last && fmt_ok && handled;
  assign push_desc.kind = kind;
  assign push_desc.addr = {frame_bytes[1], frame_bytes[2], frame_bytes[3]};
  assign push_desc.me   = {frame_bytes[4], frame_bytes[5], frame_bytes[6], frame_bytes[7],
                           frame_bytes[8], frame_bytes[9], frame_bytes[10]};

endmodule

/* rtl/adsb_queue.sv */
`timescale 1ns / 1ps
// Short frame queue between front end and field sequencer.
module adsb_queue import adsb_pkg::*; #(
  parameter int DEPTH = ADSB_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  adsb_desc_t push_desc,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output adsb_desc_t head
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  adsb_desc_t      entries [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push, do_pop;

  assign full    = (count == CntW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  // Write the new frame at the tail
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  // Advance pointers and track fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

/* rtl/adsb_back.sv */
`timescale 1ns / 1ps
// Field sequencer: walks a frame's field list and drives the registered output.
module adsb_back import adsb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  adsb_desc_t  q_head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_class,
  output logic [4:0]  out_index,
  output logic [16:0] out_value,
  output logic [23:0] out_addr,
  output logic        out_last
);

  adsb_desc_t cur;
  logic       busy;
  logic [4:0] idx;
  logic       load_out;
  logic       at_end;

  assign pop      = !busy && !q_empty;
  assign load_out = busy && (!out_valid || out_ready);
  assign at_end   = (idx == (kind_count(cur.kind) - 5'd1));

  // Take a frame from the queue and step through its fields
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (load_out) begin
      if (at_end) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
  end

  // Hold output valid until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the next field into the output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_class <= kind_class(cur.kind);
      out_index <= idx;
      out_value <= field_val(cur.kind, idx, cur.me);
      out_addr  <= cur.addr;
      out_last  <= at_end;
    end
  end

endmodule

/* rtl/ads_b_extended_squitter_decoder_unit.sv */
`timescale 1ns / 1ps
// Top level of the ADS-B extended squitter decoder.
// Input: one byte per cycle; input stalls whenever the frame queue is full.
// Path: last byte -> queue entry -> sequencer frame register -> output register (first field).
// Throughput: one field per cycle unless m_axis_tready stalls; new frame after the last field.
// The frame queue lets the front end keep collecting bytes while a run is still going out.
// Reset (rst, synchronous, active high) empties the queue, clears byte count and output valid.
module ads_b_extended_squitter_decoder_unit import adsb_pkg::*; #(
  parameter int QUEUE_DEPTH = ADSB_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_packet
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] message_class, [7:3] field_index, [24:8] field_value,
  // [48:25] aircraft_address, [55:49] zero
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast    // last_field
);

  logic        q_full, q_empty, push, pop;
  adsb_desc_t  push_desc, q_head;
  logic [2:0]  out_class;
  logic [4:0]  out_index;
  logic [16:0] out_value;
  logic [23:0] out_addr;

  adsb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc)
  );

  adsb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  adsb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_class (out_class),
    .out_index (out_index),
    .out_value (out_value),
    .out_addr  (out_addr),
    .out_last  (m_axis_tlast)
  );

  // Pack result fields, lowest field first
  assign m_axis_tdata = {7'd0, out_addr, out_value, out_index, out_class};

endmodule
